// ----- sv/crast_pkg.sv -----
// Shared types and constants for the circle octant rasteriser.
package crast_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS   = 2'd0,
    REG_CENTER_X = 2'd1,
    REG_CENTER_Y = 2'd2
  } cfg_reg_e;

  // Eight symmetric points per column
  localparam int unsigned OCT_W = 3;
  localparam logic [OCT_W-1:0] OCT_LAST = 3'd7;

  typedef struct packed {
    logic last_of_step;
    logic last_of_circle;
  } out_flags_t;

endpackage

// ----- sv/crast_sqmul.sv -----
// Bit-serial squarer: shift-add, one multiplier bit per cycle.
module crast_sqmul #(
  parameter int unsigned W = 11
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   op_i,
  output logic           busy_o,
  output logic [2*W-1:0] prod_o
);

  localparam int unsigned CW = $clog2(W);

  logic [2*W-1:0] acc_q, acc_d;
  logic [W-1:0]   mcand_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic [W:0]     sum;

  // high half plus multiplicand when the low bit is set, then shift right
  assign sum = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    acc_d = acc_q;
    if (start_i) begin
      acc_d = {{W{1'b0}}, op_i};
    end else if (busy_q) begin
      acc_d = {sum, acc_q[W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i) begin
      mcand_q <= op_i;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

// ----- sv/crast_sqrt.sv -----
// Serial integer square root: restoring method, one root bit per cycle.
module crast_sqrt #(
  parameter int unsigned W = 11
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2*W-1:0] op_i,
  output logic           busy_o,
  output logic [W-1:0]   root_o,
  output logic [W:0]     rem_o
);

  localparam int unsigned CW = $clog2(W);

  logic [2*W-1:0] opnd_q;
  logic [W:0]     rem_q;
  logic [W-1:0]   root_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic [W+2:0]   rem_t;
  logic [W+2:0]   trial;
  logic           take;

  // bring down the next operand bit pair, try (4*root + 1)
  assign rem_t = {rem_q, opnd_q[2*W-1:2*W-2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign take  = (rem_t >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opnd_q <= op_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      opnd_q <= {opnd_q[2*W-3:0], 2'b00};
      rem_q  <= take ? (rem_t[W:0] - trial[W:0]) : rem_t[W:0];
      root_q <= {root_q[W-2:0], take};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;

endmodule

// ----- sv/crast_emit.sv -----
// Point emitter: walks the eight symmetric offsets into an output register.
module crast_emit #(
  parameter int unsigned RB = 11,
  parameter int unsigned CB = 16,
  parameter int unsigned OB = 17
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [RB-1:0]          x_i,
  input  logic [RB-1:0]          y_i,
  input  logic                   last_circle_i,
  input  logic signed [CB-1:0]   center_x_i,
  input  logic signed [CB-1:0]   center_y_i,
  output logic                   idle_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OB-1:0]          point_x_o,
  output logic [OB-1:0]          point_y_o,
  output crast_pkg::out_flags_t  flags_o
);

  import crast_pkg::*;

  logic             active_q;
  logic [OCT_W-1:0] k_q;
  logic [RB-1:0]    x_q, y_q;
  logic             lc_q;
  logic             vld_q;
  logic [OB-1:0]    px_q, py_q;
  out_flags_t       flags_q;

  logic             load;
  logic [RB-1:0]    a_mag, b_mag;
  logic [OB-1:0]    a_ext, b_ext, off_a, off_b, cx_ext, cy_ext;

  assign load = active_q && (!vld_q || out_ready_i);

  // k[2] swaps the coordinates, k[1] negates the first, k[0] the second
  assign a_mag  = k_q[2] ? y_q : x_q;
  assign b_mag  = k_q[2] ? x_q : y_q;
  assign a_ext  = {{(OB-RB){1'b0}}, a_mag};
  assign b_ext  = {{(OB-RB){1'b0}}, b_mag};
  assign off_a  = k_q[1] ? (~a_ext + 1'b1) : a_ext;
  assign off_b  = k_q[0] ? (~b_ext + 1'b1) : b_ext;
  assign cx_ext = {{(OB-CB){center_x_i[CB-1]}}, center_x_i};
  assign cy_ext = {{(OB-CB){center_y_i[CB-1]}}, center_y_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      k_q      <= '0;
      vld_q    <= 1'b0;
    end else begin
      if (start_i) begin
        active_q <= 1'b1;
        k_q      <= '0;
      end else if (load) begin
        k_q <= k_q + 1'b1;
        if (k_q == OCT_LAST) begin
          active_q <= 1'b0;
        end
      end
      if (load) begin
        vld_q <= 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q  <= x_i;
      y_q  <= y_i;
      lc_q <= last_circle_i;
    end
    if (load) begin
      px_q                 <= cx_ext + off_a;
      py_q                 <= cy_ext + off_b;
      flags_q.last_of_step   <= (k_q == OCT_LAST);
      flags_q.last_of_circle <= lc_q;
    end
  end

  assign idle_o      = !active_q;
  assign out_valid_o = vld_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;
  assign flags_o     = flags_q;

`ifndef SYNTHESIS
  a_end_on_eighth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> (vld_q && flags_q.last_of_step))
    else $error("emitter finished a column without the eighth point");
`endif

endmodule

// ----- sv/circle_octant_rasteriser_unit.sv -----
// Circle octant rasteriser: one column per input step, eight symmetric points out.
// Each step runs the serial squarers, then the root unit, then the point emitter;
// at column zero the column limit root is taken first, before the column root.
// A new step is taken only in idle; points drain while the next column runs.
// Reset: async low; radius 1, centre 0, column 0, limit 1, no output pending.
module circle_octant_rasteriser_unit #(
  parameter int unsigned RADIUS_BITS = 11,
  parameter int unsigned COORD_BITS  = 16,
  localparam int unsigned OUT_BITS =
    ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : (RADIUS_BITS + 1)) + 1,
  localparam int unsigned DATA_W = ((2 * OUT_BITS + 7) / 8) * 8,
  localparam int unsigned CFG_W  = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [crast_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]                cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [0] restart
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [DATA_W-1:0]               m_axis_tdata,   // point_x, point_y
  output logic                            m_axis_tlast,   // last_of_step
  output logic                            m_axis_tuser    // last_of_circle
);

  import crast_pkg::*;

  localparam int unsigned SQ_W = 2 * RADIUS_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_LIM  = 4'b0100,
    ST_ROOT = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [RADIUS_BITS-1:0] radius_q;
  logic [COORD_BITS-1:0]  center_x_q, center_y_q;
  logic [RADIUS_BITS-1:0] column_q, column_d;
  logic [RADIUS_BITS-1:0] limit_q, limit_d;
  logic [RADIUS_BITS-1:0] x_q, x_d;

  logic                   in_xfer;
  logic                   mul_start;
  logic                   mul_r_busy, mul_x_busy;
  logic [SQ_W-1:0]        r_sq, x_sq;
  logic [SQ_W:0]          diff;
  logic [SQ_W-1:0]        n_val;
  logic                   sqrt_start;
  logic [SQ_W-1:0]        sqrt_op;
  logic                   sqrt_busy;
  logic [RADIUS_BITS-1:0] root;
  logic [RADIUS_BITS:0]   rem;
  logic [RADIUS_BITS-1:0] y_val;
  logic                   last_col;
  logic                   emit_start;
  logic                   emit_idle;
  logic [OUT_BITS-1:0]    point_x, point_y;
  out_flags_t             flags;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RADIUS_BITS'(1);
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_RADIUS:   radius_q   <= cfg_data_i[RADIUS_BITS-1:0];
        REG_CENTER_X: center_x_q <= cfg_data_i[COORD_BITS-1:0];
        REG_CENTER_Y: center_y_q <= cfg_data_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // r*r - x*x, clamped at zero when the radius shrank mid-circle
  assign diff  = {1'b0, r_sq} - {1'b0, x_sq};
  assign n_val = diff[SQ_W] ? '0 : diff[SQ_W-1:0];

  // round to nearest: bump when the remainder exceeds the floor root
  assign y_val    = root + RADIUS_BITS'(rem > {1'b0, root});
  assign last_col = (x_q >= limit_q);

  always_comb begin
    state_d    = state_q;
    column_d   = column_q;
    limit_d    = limit_q;
    x_d        = x_q;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    sqrt_op    = n_val;
    emit_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          x_d       = s_axis_tdata[0] ? '0 : column_q;
          mul_start = 1'b1;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!mul_r_busy && !mul_x_busy) begin
          sqrt_start = 1'b1;
          if (x_q == '0) begin
            sqrt_op = {1'b0, r_sq[SQ_W-1:1]};
            state_d = ST_LIM;
          end else begin
            state_d = ST_ROOT;
          end
        end
      end
      ST_LIM: begin
        if (!sqrt_busy) begin
          limit_d    = root + 1'b1;
          sqrt_start = 1'b1;
          state_d    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (!sqrt_busy && emit_idle) begin
          emit_start = 1'b1;
          column_d   = last_col ? '0 : (x_q + 1'b1);
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      column_q <= '0;
      limit_q  <= RADIUS_BITS'(1);
    end else begin
      state_q  <= state_d;
      column_q <= column_d;
      limit_q  <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  crast_sqmul #(.W(RADIUS_BITS)) u_sq_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .op_i    (radius_q),
    .busy_o  (mul_r_busy),
    .prod_o  (r_sq)
  );

  crast_sqmul #(.W(RADIUS_BITS)) u_sq_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .op_i    (x_d),
    .busy_o  (mul_x_busy),
    .prod_o  (x_sq)
  );

  crast_sqrt #(.W(RADIUS_BITS)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .op_i    (sqrt_op),
    .busy_o  (sqrt_busy),
    .root_o  (root),
    .rem_o   (rem)
  );

  crast_emit #(
    .RB (RADIUS_BITS),
    .CB (COORD_BITS),
    .OB (OUT_BITS)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (emit_start),
    .x_i           (x_q),
    .y_i           (y_val),
    .last_circle_i (last_col),
    .center_x_i    (center_x_q),
    .center_y_i    (center_y_q),
    .idle_o        (emit_idle),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .point_x_o     (point_x),
    .point_y_o     (point_y),
    .flags_o       (flags)
  );

  assign m_axis_tdata = DATA_W'({point_y, point_x});
  assign m_axis_tlast = flags.last_of_step;
  assign m_axis_tuser = flags.last_of_circle;

`ifndef SYNTHESIS
  // a restart can recompute a smaller limit while the old column is still held
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (column_q <= limit_q))
    else $error("column ran past the column limit");

  a_limit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_q != '0)
    else $error("column limit is zero");

  a_lim_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIM) |-> (x_q == '0))
    else $error("limit recomputed away from column zero");

  a_squarers_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (mul_r_busy && mul_x_busy))
    else $error("squarers not started on input transfer");
`endif

endmodule
